FILE: src/nms_pkg.sv
`default_nettype none
// ============================================================================
// nms_pkg: shared types and constants for edge non-maximum suppression
// Field widths, line-store geometry, angle sector codes and the request
// record that travels from the front end through the queue to the back end.
// ============================================================================
package nms_pkg;

    // Line store geometry (LINE_MAX must be a power of two)
    localparam int LINE_MAX    = 2048;
    localparam int LINE_AW     = $clog2(LINE_MAX);
    localparam int CNT_W       = LINE_AW + 1;

    // Field widths
    localparam int MAG_W       = 16;
    localparam int ANG_W       = 13;
    localparam int FW_W        = 12;
    localparam int FH_W        = 16;
    localparam int WCMP_W      = (CNT_W > FW_W) ? CNT_W : FW_W;
    localparam int SEC_W       = 3;

    // Port widths
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 16;

    // Queue between front and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] WIDTH_RESET  = FW_W'(640);
    localparam logic [FH_W-1:0] HEIGHT_RESET = FH_W'(480);

    // Neighbor pair chosen by the gradient angle
    localparam logic [SEC_W-1:0] SEC_VERT = 3'd0;
    localparam logic [SEC_W-1:0] SEC_ANTI = 3'd1;
    localparam logic [SEC_W-1:0] SEC_HORZ = 3'd2;
    localparam logic [SEC_W-1:0] SEC_DIAG = 3'd3;
    localparam logic [SEC_W-1:0] SEC_KEEP = 3'd4;

    // Angle bounds in 1/16 degree
    localparam logic signed [ANG_W:0] ANG_HALF_TURN = (ANG_W+1)'(2880);
    localparam logic signed [ANG_W:0] ANG_22_5      = (ANG_W+1)'(360);
    localparam logic signed [ANG_W:0] ANG_67_5      = (ANG_W+1)'(1080);
    localparam logic signed [ANG_W:0] ANG_112_5     = (ANG_W+1)'(1800);
    localparam logic signed [ANG_W:0] ANG_157_5     = (ANG_W+1)'(2520);

    typedef struct packed {
        logic emit;   // this request releases a result
        logic last;   // released result closes the frame
        logic up;     // neighbor row above exists
        logic dn;     // neighbor row below exists
        logic lf;     // neighbor column to the left exists
        logic rt;     // neighbor column to the right exists
    } nms_flags_t;

    typedef struct packed {
        nms_flags_t             flags;
        logic [MAG_W-1:0]       mag;   // magnitude entering the window, bottom row
        logic [MAG_W-1:0]       top;   // line store, two rows up
        logic [MAG_W-1:0]       mid;   // line store, one row up
        logic [SEC_W-1:0]       sec;   // sector read from the sector line
    } nms_entry_t;

    // Fold the angle into 0..180 degrees and pick the neighbor pair
    function automatic logic [SEC_W-1:0] angle_sector(input logic signed [ANG_W-1:0] ang);
        logic signed [ANG_W:0] a;
        logic [SEC_W-1:0]      sec;
        a = {ang[ANG_W-1], ang};
        if (a < 0)
        begin
            a = a + ANG_HALF_TURN;
        end
        if (a <= ANG_22_5 || a > ANG_157_5)
        begin
            sec = SEC_VERT;
        end
        else if (a < ANG_67_5)
        begin
            sec = SEC_ANTI;
        end
        else if (a == ANG_67_5)
        begin
            sec = SEC_KEEP;
        end
        else if (a <= ANG_112_5)
        begin
            sec = SEC_HORZ;
        end
        else
        begin
            sec = SEC_DIAG;
        end
        return sec;
    endfunction

endpackage
`default_nettype wire

FILE: src/nms_ram.sv
`default_nettype none
// ============================================================================
// nms_ram: generic simple dual-port RAM
// One write port, one read port, registered read data (old data on a
// same-address read and write).
// ============================================================================
module nms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: src/nms_front.sv
`default_nettype none
// ============================================================================
// nms_front: input side of non-maximum suppression
// Holds the frame registers and counters, classifies each request, updates
// the line stores and hands a complete window column to the queue.
// ============================================================================
module nms_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nms_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               in_kind,
    input  logic [nms_pkg::MAG_W-1:0]          in_mag,
    input  logic signed [nms_pkg::ANG_W-1:0]   in_angle,
    output logic                               q_valid,
    input  logic                               q_ready,
    output nms_pkg::nms_entry_t                q_data
);
    import nms_pkg::*;

    logic [FW_W-1:0]    width_reg;
    logic [FH_W-1:0]    height_reg;
    logic [LINE_AW-1:0] in_col_reg, in_col_next;
    logic [FH_W-1:0]    in_row_reg, in_row_next;
    logic [LINE_AW-1:0] out_col_reg, out_col_next;
    logic [FH_W-1:0]    out_row_reg, out_row_next;
    logic [CNT_W-1:0]   pend_reg, pend_next;

    logic               s1_valid_reg, s1_valid_next;
    nms_flags_t         s1_flags_reg;
    logic [MAG_W-1:0]   s1_mag_reg;
    logic               s1_par_reg;

    logic [WCMP_W-1:0]  width_ext;
    logic [CNT_W-1:0]   w_eff;
    logic [FH_W-1:0]    h_eff;
    logic               cfg_wr;
    logic               accept;
    logic               in_frame;
    logic               proc;
    logic               par;
    logic [MAG_W-1:0]   mag_in;
    logic [SEC_W-1:0]   sec_in;
    logic [CNT_W-1:0]   col_p1;
    logic               col_wrap;
    logic [CNT_W-1:0]   pend_inc;
    logic [CNT_W-1:0]   ocol_p1;
    logic [FH_W:0]      orow_p1;
    logic               emit;
    logic               frame_end;
    nms_flags_t         flags;
    logic [MAG_W-1:0]   rd0, rd1;
    logic [SEC_W-1:0]   sec_rd;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    // Effective frame size
    assign width_ext = WCMP_W'(width_reg);
    always_comb
    begin
        if (width_ext == '0)
        begin
            w_eff = CNT_W'(1);
        end
        else if (width_ext > WCMP_W'(LINE_MAX))
        begin
            w_eff = CNT_W'(LINE_MAX);
        end
        else
        begin
            w_eff = CNT_W'(width_ext);
        end
    end
    assign h_eff = (height_reg == '0) ? FH_W'(1) : height_reg;

    // Classify: a flush tick inside the frame is dropped with no effect
    assign in_ready = ~s1_valid_reg | q_ready;
    assign accept   = in_valid & in_ready;
    assign in_frame = in_row_reg < h_eff;
    assign proc     = accept & ~(in_frame & in_kind);
    assign par      = in_row_reg[0];
    assign mag_in   = in_frame ? in_mag : '0;
    assign sec_in   = in_frame ? angle_sector(in_angle) : SEC_VERT;

    assign col_p1   = {1'b0, in_col_reg} + CNT_W'(1);
    assign col_wrap = col_p1 >= w_eff;
    assign pend_inc = pend_reg + CNT_W'(in_frame);
    assign emit     = (pend_inc > (w_eff + CNT_W'(1))) || (~in_frame && pend_inc != '0);

    assign ocol_p1   = {1'b0, out_col_reg} + CNT_W'(1);
    assign orow_p1   = {1'b0, out_row_reg} + (FH_W+1)'(1);
    assign flags.emit = emit;
    assign flags.up   = out_row_reg != '0;
    assign flags.dn   = orow_p1 < {1'b0, h_eff};
    assign flags.lf   = out_col_reg != '0;
    assign flags.rt   = ocol_p1 < w_eff;
    assign frame_end  = ~flags.dn & ~flags.rt;
    assign flags.last = emit & frame_end;

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pend_next    = pend_reg;
        if (proc)
        begin
            if (col_wrap)
            begin
                in_col_next = '0;
                if (in_frame)
                begin
                    in_row_next = in_row_reg + FH_W'(1);
                end
            end
            else
            begin
                in_col_next = col_p1[LINE_AW-1:0];
            end
            pend_next = pend_inc - CNT_W'(emit);
            if (emit)
            begin
                if (frame_end)
                begin
                    // frame done: start the next one from the origin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    pend_next    = '0;
                end
                else if (ocol_p1 >= w_eff)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + FH_W'(1);
                end
                else
                begin
                    out_col_next = ocol_p1[LINE_AW-1:0];
                end
            end
        end
        if (cfg_wr)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            pend_next    = '0;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (proc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_valid_reg && q_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            pend_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr && cfg_index == REG_FRAME_WIDTH)
            begin
                width_reg <= cfg_data[FW_W-1:0];
            end
            if (cfg_wr && cfg_index == REG_FRAME_HEIGHT)
            begin
                height_reg <= cfg_data[FH_W-1:0];
            end
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            pend_reg     <= pend_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            s1_flags_reg <= flags;
            s1_mag_reg   <= mag_in;
            s1_par_reg   <= par;
        end
    end

    // Even and odd row banks, plus one row of sectors
    nms_ram #(.WIDTH(MAG_W), .DEPTH(LINE_MAX)) u_bank0 (
        .clk   (clk),
        .we    (proc & ~par),
        .waddr (in_col_reg),
        .wdata (mag_in),
        .re    (proc),
        .raddr (in_col_reg),
        .rdata (rd0)
    );

    nms_ram #(.WIDTH(MAG_W), .DEPTH(LINE_MAX)) u_bank1 (
        .clk   (clk),
        .we    (proc & par),
        .waddr (in_col_reg),
        .wdata (mag_in),
        .re    (proc),
        .raddr (in_col_reg),
        .rdata (rd1)
    );

    nms_ram #(.WIDTH(SEC_W), .DEPTH(LINE_MAX)) u_sector (
        .clk   (clk),
        .we    (proc),
        .waddr (in_col_reg),
        .wdata (sec_in),
        .re    (proc),
        .raddr (in_col_reg),
        .rdata (sec_rd)
    );

    assign q_valid      = s1_valid_reg;
    assign q_data.flags = s1_flags_reg;
    assign q_data.mag   = s1_mag_reg;
    assign q_data.top   = s1_par_reg ? rd1 : rd0;
    assign q_data.mid   = s1_par_reg ? rd0 : rd1;
    assign q_data.sec   = sec_rd;

endmodule
`default_nettype wire

FILE: src/nms_queue.sv
`default_nettype none
// ============================================================================
// nms_queue: short request queue between front and back end
// Registered slots with read and write pointers.
// ============================================================================
module nms_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  nms_pkg::nms_entry_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output nms_pkg::nms_entry_t pop_data
);
    import nms_pkg::*;

    nms_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push, pop;

    assign push_ready = count_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid & push_ready;
    assign pop        = pop_valid & pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

FILE: src/nms_back.sv
`default_nettype none
// ============================================================================
// nms_back: window and suppression decision
// Shifts each request into the 3x3 magnitude window, compares the center
// against the chosen neighbor pair and holds the result for the output.
// ============================================================================
module nms_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  nms_pkg::nms_entry_t            q_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [nms_pkg::M_DATA_W-1:0]   out_value,
    output logic                           out_last
);
    import nms_pkg::*;

    // win_reg[row][0] is the left-hand column, win_reg[row][1] the center column
    logic [MAG_W-1:0]    win_reg [3][2];
    logic [SEC_W-1:0]    sec_hold_reg;
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_value_reg;
    logic                out_last_reg;

    logic                pop;
    logic [MAG_W-1:0]    cm;
    logic                sup;
    nms_flags_t          f;

    assign f       = q_data.flags;
    assign q_ready = ~f.emit | ~out_valid_reg | out_ready;
    assign pop     = q_valid & q_ready;
    assign cm      = win_reg[1][1];

    always_comb
    begin
        case (sec_hold_reg)
            SEC_VERT:
            begin
                sup = (f.up && cm < win_reg[0][1]) || (f.dn && cm < win_reg[2][1]);
            end
            SEC_ANTI:
            begin
                sup = (f.up && f.rt && cm < q_data.top) || (f.dn && f.lf && cm < win_reg[2][0]);
            end
            SEC_HORZ:
            begin
                sup = (f.lf && cm < win_reg[1][0]) || (f.rt && cm < q_data.mid);
            end
            SEC_DIAG:
            begin
                sup = (f.up && f.lf && cm < win_reg[0][0]) || (f.dn && f.rt && cm < q_data.mag);
            end
            default:
            begin
                sup = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k][0] <= '0;
                win_reg[k][1] <= '0;
            end
            sec_hold_reg  <= SEC_VERT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[k][0] <= win_reg[k][1];
                end
                win_reg[0][1] <= q_data.top;
                win_reg[1][1] <= q_data.mid;
                win_reg[2][1] <= q_data.mag;
                sec_hold_reg  <= q_data.sec;
            end
            if (pop && f.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && f.emit)
        begin
            out_value_reg <= sup ? '0 : M_DATA_W'(cm);
            out_last_reg  <= f.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

FILE: src/edge_non_maximum_suppression_top.sv
`default_nettype none
// ============================================================================
// edge_non_maximum_suppression_top: Canny non-maximum suppression on a stream
// Latency: a result leaves width+1 requests after its pixel, then passes the
//   front stage register, the queue slot and the output register to m_tvalid.
// Throughput: one request per cycle unless the output stalls, bounded by the
//   single read and write per request on each line-store RAM.
// Reset: counters clear, width 640 and height 480; line stores are not
//   cleared, since no entry is used before the current frame writes it.
// ============================================================================
module edge_non_maximum_suppression_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nms_pkg::CFG_IDX_W-1:0]      cfg_index,  // 0 frame_width, 1 frame_height
    input  logic [nms_pkg::CFG_DATA_W-1:0]     cfg_data,
    // pixel requests
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [nms_pkg::S_DATA_W-1:0]       s_tdata,    // [15:0] grad_magnitude, [28:16] grad_angle
    input  logic                               s_tuser,    // [0] kind: 0 pixel, 1 flush tick
    // results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [nms_pkg::M_DATA_W-1:0]       m_tdata,    // [15:0] edge_value
    output logic                               m_tlast     // frame_last
);
    import nms_pkg::*;

    logic       fq_valid, fq_ready;
    nms_entry_t fq_data;
    logic       bq_valid, bq_ready;
    nms_entry_t bq_data;

    // Front end: classify each request, advance frame counters, read and
    // write the line stores, and build one window column per request that is not dropped.
    nms_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_mag    (s_tdata[MAG_W-1:0]),
        .in_angle  (s_tdata[MAG_W+ANG_W-1:MAG_W]),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_data    (fq_data)
    );

    // Decouple the two halves so either side can stall without losing a slot.
    nms_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (bq_valid),
        .pop_ready  (bq_ready),
        .pop_data   (bq_data)
    );

    // Back end: shift the window, decide suppression, hold the result until
    // the downstream side takes it.
    nms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (bq_valid),
        .q_ready   (bq_ready),
        .q_data    (bq_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (m_tdata),
        .out_last  (m_tlast)
    );

    // Input side only stalls when the front stage is full and the queue refuses it.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (fq_valid && !fq_ready))
        else $error("input stalled without a blocked front stage");

    // A frame end is only marked on a request that releases a result.
    a_last_needs_emit: assert property (@(posedge clk) disable iff (!rst_n)
        bq_valid |-> (!bq_data.flags.last || bq_data.flags.emit))
        else $error("frame end marked on a request with no result");

    // Every releasing request taken by the back end shows up on the output.
    a_emit_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (bq_valid && bq_ready && bq_data.flags.emit) |=> m_tvalid)
        else $error("released result missing on output");

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top: stream testbench for edge_non_maximum_suppression_top
// Pixel and flush requests go in from a queue through a clocked driver. A
// line-buffer model of the suppression works out each released edge value.
// A clocked monitor compares every result with the oldest prediction.
// Runs go through frame geometries from one pixel wide up to a width held
// to the line store.
// ============================================================================
module tb_top;

    // Kind of an input request, carried on s_tuser
    typedef enum bit
    {
        KIND_PIXEL = 1'b0,
        KIND_FLUSH = 1'b1
    } kind_e;

    typedef struct
    {
        kind_e                              kind;
        logic [nms_pkg::MAG_W-1:0]          mag;
        logic signed [nms_pkg::ANG_W-1:0]   ang;
    } pix_t;

    typedef struct
    {
        logic [nms_pkg::MAG_W-1:0]          value;
        logic                               closes;   // frame_last
    } edge_t;

    // Angle bounds in 1/16 degree
    localparam int HALF_TURN   = 2880;
    localparam int DEG_22_5    = 360;
    localparam int DEG_67_5    = 1080;
    localparam int DEG_112_5   = 1800;
    localparam int DEG_157_5   = 2520;

    localparam int PHASE_ITEMS     = 70;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 12;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int REPORT_LIMIT    = 200;
    localparam int DIR_N           = 18;
    localparam int ANGLE_MARK_N    = 21;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   cfg_valid = 1'b0;
    logic                                   cfg_ready;
    logic [nms_pkg::CFG_IDX_W-1:0]          cfg_index = '0;
    logic [nms_pkg::CFG_DATA_W-1:0]         cfg_data = '0;
    logic                                   s_tvalid = 1'b0;
    logic                                   s_tready;
    logic [nms_pkg::S_DATA_W-1:0]           s_tdata = '0;
    logic                                   s_tuser = 1'b0;
    logic                                   m_tvalid;
    logic                                   m_tready = 1'b0;
    logic [nms_pkg::M_DATA_W-1:0]           m_tdata;
    logic                                   m_tlast;

    edge_non_maximum_suppression_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // ------------------------------------------------------------------------
    // Suppression model state: register copies, two magnitude lines, one
    // sector line, the 3x3 window and the raster counters.
    // ------------------------------------------------------------------------
    logic [nms_pkg::FW_W-1:0]   width_reg;
    logic [nms_pkg::FH_W-1:0]   height_reg;
    bit [nms_pkg::MAG_W-1:0]    mag_line [2][nms_pkg::LINE_MAX];
    bit [nms_pkg::SEC_W-1:0]    sec_line [nms_pkg::LINE_MAX];
    bit [nms_pkg::MAG_W-1:0]    win [3][3];
    bit [nms_pkg::SEC_W-1:0]    sec_held;
    int unsigned                in_col, in_row, out_col, out_row, pend_count;

    // Stimulus and checking state
    pix_t                       pixel_fifo [$];
    edge_t                      edge_expect [$];
    int                         send_idle_pct = 0;
    int                         recv_stall_pct = 0;
    int unsigned                sent_count;
    int                         mismatch_count = 0;
    int                         quiet_cycles = 0;
    bit                         pix_took = 1'b0;
    pix_t                       seen_pix;
    bit                         released;
    edge_t                      new_edge;
    edge_t                      want;

    // Angles on and around every sector boundary
    int angle_marks [ANGLE_MARK_N] = '{
        -2880, -2879, -2521, -2520, -1801, -1800, -1080, -361, -360, -1, 0,
        1, 360, 361, 1079, 1080, 1081, 1800, 1801, 2520, 2521
    };

    // Two 3x3 frames: extremes of the magnitude and one pixel per sector
    // boundary, then near-equal magnitudes to probe the strict compare.
    logic [15:0] dir_mag [DIR_N] = '{
        16'hFFFF, 16'h0000, 16'h8000, 16'h1234, 16'h7FFF, 16'h0001,
        16'hFFFF, 16'h8000, 16'h0001,
        16'h5555, 16'h5555, 16'h5556, 16'h5554, 16'h5555, 16'h5555,
        16'h5556, 16'h5555, 16'h5554
    };
    int dir_ang [DIR_N] = '{
        0, -2880, 2880, 361, 1080, 1081, 1800, 1801, 2520,
        -1, 360, 1079, 2521, -1080, -360, -1800, -2520, 1
    };

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int unsigned eff_width();
        int unsigned v;
        v = width_reg;
        if (v < 1)
            v = 1;
        if (v > nms_pkg::LINE_MAX)
            v = nms_pkg::LINE_MAX;
        return v;
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg < 1) ? 1 : height_reg;
    endfunction

    // Fold the angle into 0..180 degrees and pick the neighbor pair
    function automatic logic [nms_pkg::SEC_W-1:0] pick_sector(
        input logic signed [nms_pkg::ANG_W-1:0] ang);
        int a;
        a = ang;
        if (a < 0)
            a = a + HALF_TURN;
        if (a <= DEG_22_5 || a > DEG_157_5)
            return nms_pkg::SEC_VERT;
        if (a < DEG_67_5)
            return nms_pkg::SEC_ANTI;
        if (a == DEG_67_5)
            return nms_pkg::SEC_KEEP;
        if (a <= DEG_112_5)
            return nms_pkg::SEC_HORZ;
        return nms_pkg::SEC_DIAG;
    endfunction

    // Advance the model by one accepted request; fired tells whether the
    // request releases the edge value of the pixel one row and one pixel back.
    task automatic suppress_step(input pix_t p, output bit fired, output edge_t res);
        int unsigned w, h, ic, par, r, c, k;
        bit in_frame, up, dn, lf, rt, sup, closes;
        bit [nms_pkg::MAG_W-1:0] m, cm;
        bit [nms_pkg::SEC_W-1:0] csec;
        fired = 1'b0;
        res.value = '0;
        res.closes = 1'b0;
        w = eff_width();
        h = eff_height();
        in_frame = in_row < h;
        // A flush tick in the middle of a frame leaves everything alone
        if (in_frame && p.kind == KIND_FLUSH)
            return;
        ic = in_col;
        par = in_row & 1;
        m = in_frame ? p.mag : '0;
        for (k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = mag_line[par][ic];
        win[1][2] = mag_line[par ^ 1][ic];
        win[2][2] = m;
        mag_line[par][ic] = m;
        csec = sec_held;
        sec_held = sec_line[ic];
        sec_line[ic] = in_frame ? pick_sector(p.ang) : nms_pkg::SEC_VERT;

        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            if (in_row < h)
                in_row++;
        end
        if (in_frame)
            pend_count++;
        if (!(pend_count > w + 1 || (!in_frame && pend_count > 0)))
            return;
        pend_count--;

        r = out_row;
        c = out_col;
        cm = win[1][1];
        up = r >= 1;
        dn = r + 1 < h;
        lf = c >= 1;
        rt = c + 1 < w;
        case (csec)
            nms_pkg::SEC_VERT:
                sup = (up && cm < win[0][1]) || (dn && cm < win[2][1]);
            nms_pkg::SEC_ANTI:
                sup = (up && rt && cm < win[0][2]) || (dn && lf && cm < win[2][0]);
            nms_pkg::SEC_HORZ:
                sup = (lf && cm < win[1][0]) || (rt && cm < win[1][2]);
            nms_pkg::SEC_DIAG:
                sup = (up && lf && cm < win[0][0]) || (dn && rt && cm < win[2][2]);
            default:
                sup = 1'b0;
        endcase
        closes = (r + 1 >= h) && (c + 1 >= w);
        res.value = sup ? '0 : cm;
        res.closes = closes;
        fired = 1'b1;
        if (closes)
        begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
            pend_count = 0;
        end
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    // Write one register through the configuration channel; any write
    // abandons the frame in progress, so restart the model counters too.
    task automatic write_reg(input logic [nms_pkg::CFG_IDX_W-1:0] idx,
                             input logic [nms_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (idx == nms_pkg::REG_FRAME_WIDTH)
            width_reg = val[nms_pkg::FW_W-1:0];
        else
            height_reg = val;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        pend_count = 0;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold until every request is taken and every edge value has come back,
    // then give the back end time to settle.
    task automatic wait_idle();
        while (pixel_fifo.size() != 0 || edge_expect.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic pix_t rand_pixel(input kind_e k, input int style);
        pix_t p;
        int a;
        p.kind = k;
        case (style)
            0: p.mag = 16'($urandom);
            1: p.mag = 16'($urandom_range(0, 3));
            default: p.mag = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'($urandom_range(0, 1));
        endcase
        if ($urandom_range(0, 3) == 0)
            a = angle_marks[$urandom_range(0, ANGLE_MARK_N - 1)];
        else
            a = int'($urandom_range(0, 2 * HALF_TURN)) - HALF_TURN;
        p.ang = a[nms_pkg::ANG_W-1:0];
        return p;
    endfunction

    // Queue npix pixels of a w x h frame, with flush ticks mixed in at random; a complete
    // frame gets its drain, part of which are pixels whose data the block must drop.
    task automatic push_frame(input int unsigned w, input int unsigned h,
                              input int unsigned npix);
        int unsigned i, ndrain;
        int style;
        style = $urandom_range(0, 2);
        for (i = 0; i < npix; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                pixel_fifo.push_back(rand_pixel(KIND_FLUSH, style));
            pixel_fifo.push_back(rand_pixel(KIND_PIXEL, style));
        end
        ndrain = 0;
        if (npix == w * h)
            ndrain = (npix < w + 1) ? npix : w + 1;
        for (i = 0; i < ndrain; i++)
            pixel_fifo.push_back(rand_pixel(($urandom_range(0, 9) < 3) ? KIND_PIXEL : KIND_FLUSH,
                                            style));
        sent_count += npix + ndrain;
    endtask

    // ------------------------------------------------------------------------
    // Driver: present the head of the request queue at the falling edge and
    // keep it steady until it is taken; idle between requests at random.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (pix_took)
            void'(pixel_fifo.pop_front());
        if (!s_tvalid || pix_took)
        begin
            if (pixel_fifo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {3'b000, pixel_fifo[0].ang, pixel_fifo[0].mag};
                s_tuser  <= pixel_fifo[0].kind;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall the result side at random
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on every accepted request, check every accepted
    // result against the oldest prediction, and watch for a hung block.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        pix_took <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                // s_tdata: [15:0] magnitude, [28:16] angle
                seen_pix.kind = kind_e'(s_tuser);
                seen_pix.mag  = s_tdata[15:0];
                seen_pix.ang  = s_tdata[28:16];
                suppress_step(seen_pix, released, new_edge);
                if (released)
                    edge_expect.push_back(new_edge);
            end
            if (m_tvalid && m_tready)
            begin
                if (edge_expect.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: result with none expected: edge_value %h frame_last %b",
                                 $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = edge_expect.pop_front();
                    if (m_tdata !== want.value)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: edge_value expected %h actual %h",
                                     $time, want.value, m_tdata);
                    end
                    if (m_tlast !== want.closes)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: frame_last expected %b actual %b",
                                     $time, want.closes, m_tlast);
                    end
                end
            end
            // Any handshake counts as progress
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[edge_non_maximum_suppression_top] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: directed frames, then four phases of random frames under varying idle and stall rates.
    // ------------------------------------------------------------------------
    initial
    begin
        pix_t d;
        int unsigned phase, sel, cw, ch, w, h, i, j, n;
        logic [3:0] junk;

        width_reg  = nms_pkg::WIDTH_RESET;
        height_reg = nms_pkg::HEIGHT_RESET;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        pend_count = 0;
        sec_held = '0;
        sent_count = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: two 3x3 frames, a flush tick inside each frame and a
        // pixel inside each drain
        write_reg(nms_pkg::REG_FRAME_WIDTH, 16'd3);
        write_reg(nms_pkg::REG_FRAME_HEIGHT, 16'd3);
        for (i = 0; i < DIR_N; i++)
        begin
            d.kind = KIND_PIXEL;
            d.mag  = dir_mag[i];
            d.ang  = dir_ang[i][nms_pkg::ANG_W-1:0];
            if (i % 9 == 4)
            begin
                d.kind = KIND_FLUSH;
                pixel_fifo.push_back(d);
                d.kind = KIND_PIXEL;
            end
            pixel_fifo.push_back(d);
            if (i % 9 == 8)
            begin
                for (j = 0; j < 4; j++)
                begin
                    d.kind = (j == 1) ? KIND_PIXEL : KIND_FLUSH;
                    d.mag  = 16'hABCD;
                    pixel_fifo.push_back(d);
                end
            end
        end
        wait_idle();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 73;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 73;
                end
                default:
                begin
                    send_idle_pct = 27;
                    recv_stall_pct = 27;
                end
            endcase

            if (phase == 0)
            begin
                // One row, height zero held to one; upper width bits dropped
                write_reg(nms_pkg::REG_FRAME_WIDTH, 16'hF005);
                write_reg(nms_pkg::REG_FRAME_HEIGHT, 16'h0000);
                push_frame(5, 1, 5);
                wait_idle();
                // Width beyond the line store is held to it; drop the frame
                // a few pixels into its first row
                write_reg(nms_pkg::REG_FRAME_WIDTH, 16'hFFFF);
                write_reg(nms_pkg::REG_FRAME_HEIGHT, 16'hFFFF);
                push_frame(nms_pkg::LINE_MAX, 65535, 24);
                wait_idle();
            end

            sent_count = 0;
            while (sent_count < PHASE_ITEMS)
            begin
                sel = $urandom_range(0, 5);
                case (sel)
                    0:
                    begin
                        cw = 3;
                        ch = 3;
                    end
                    1:
                    begin
                        cw = $urandom_range(0, 1);
                        ch = $urandom_range(1, 6);
                    end
                    2:
                    begin
                        cw = $urandom_range(3, 12);
                        ch = $urandom_range(0, 8);
                    end
                    3:
                    begin
                        cw = 2;
                        ch = $urandom_range(2, 5);
                    end
                    4:
                    begin
                        cw = $urandom_range(13, 20);
                        ch = 3;
                    end
                    default:
                    begin
                        cw = $urandom_range(3, 10);
                        ch = 65535;
                    end
                endcase
                // Upper data bits are outside the width register
                junk = 4'($urandom);
                write_reg(nms_pkg::REG_FRAME_WIDTH, {junk, cw[11:0]});
                write_reg(nms_pkg::REG_FRAME_HEIGHT, ch[15:0]);
                w = eff_width();
                h = eff_height();
                if (sel == 5)
                begin
                    // Tall frame: run a few rows, then abandon it
                    push_frame(w, h, $urandom_range(w + 2, 4 * w));
                end
                else
                begin
                    n = $urandom_range(1, 3);
                    repeat (n) push_frame(w, h, w * h);
                    if ($urandom_range(0, 5) == 0)
                        push_frame(w, h, $urandom_range(1, w * h));
                end
                wait_idle();
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && edge_expect.size() == 0)
            $display("[edge_non_maximum_suppression_top] OK");
        else
            $display("[edge_non_maximum_suppression_top] ERROR");
        $finish;
    end

endmodule
